// ----- rtl/assert_macros.svh -----
// Assertion helpers for clocked checks with synchronous active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_AT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sps_pkg.sv -----
package sps_pkg;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_MOVE = 2'd1,
        REQ_OFF  = 2'd2
    } t_req_type;

    localparam logic       CFG_DRIVE_MODE = 1'b0;
    localparam logic       CFG_STEP_DELAY = 1'b1;

    localparam logic       MODE_HALF = 1'b0;
    localparam logic       MODE_WAVE = 1'b1;

    localparam logic [15:0] STEP_DELAY_RESET = 16'd2944;

    localparam logic [3:0] HALF_TABLE [8] = '{
        4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9
    };
    localparam logic [3:0] WAVE_TABLE [4] = '{4'd1, 4'd2, 4'd4, 4'd8};

    typedef struct packed {
        t_req_type   req_type;
        logic [15:0] step_count;
    } t_req;

    typedef struct packed {
        logic [3:0] coils;
        logic       busy_res;
        logic       done_res;
        logic       rejected;
    } t_result;

    function automatic logic [3:0] coil_lookup(input logic mode, input logic [2:0] phase);
        logic [3:0] bits;
        if (mode == MODE_WAVE) begin
            bits = WAVE_TABLE[phase[1:0]];
        end else begin
            bits = HALF_TABLE[phase];
        end
        return bits;
    endfunction

endpackage

// ----- rtl/sps_core.sv -----
module sps_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  sps_pkg::t_req     i_req,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output sps_pkg::t_result  o_result
);

    logic        r_drive_mode, n_drive_mode;
    logic [15:0] r_step_delay, n_step_delay;
    logic [2:0]  r_phase, n_phase;
    logic        r_energised, n_energised;
    logic [15:0] r_steps_left, n_steps_left;
    logic        r_reverse, n_reverse;
    logic [15:0] r_delay_left, n_delay_left;
    logic        r_moving, n_moving;

    logic        take_step;
    logic        step_reverse;
    logic        done;
    logic        rej;
    logic [2:0]  stepped_phase;
    logic [15:0] delay_load;
    logic [15:0] move_mag;

    assign delay_load = (r_step_delay == 16'd0) ? 16'd1 : r_step_delay;
    assign move_mag   = i_req.step_count[15] ? (16'd0 - i_req.step_count) : i_req.step_count;

    always_comb begin
        if (r_drive_mode == sps_pkg::MODE_WAVE) begin
            stepped_phase = step_reverse ? {1'b0, r_phase[1:0] - 2'd1}
                                         : {1'b0, r_phase[1:0] + 2'd1};
        end else begin
            stepped_phase = step_reverse ? r_phase - 3'd1 : r_phase + 3'd1;
        end
    end

    always_comb begin
        n_drive_mode = r_drive_mode;
        n_step_delay = r_step_delay;
        n_phase      = r_phase;
        n_energised  = r_energised;
        n_steps_left = r_steps_left;
        n_reverse    = r_reverse;
        n_delay_left = r_delay_left;
        n_moving     = r_moving;
        take_step    = 1'b0;
        step_reverse = r_reverse;
        done         = 1'b0;
        rej          = 1'b0;

        if (i_fire) begin
            case (i_req.req_type)
                sps_pkg::REQ_TICK: begin
                    if (r_moving) begin
                        if (r_delay_left <= 16'd1) begin
                            n_delay_left = 16'd0;
                            if (r_steps_left != 16'd0) begin
                                take_step    = 1'b1;
                                n_steps_left = r_steps_left - 16'd1;
                            end else begin
                                n_moving = 1'b0;
                                done     = 1'b1;
                            end
                        end else begin
                            n_delay_left = r_delay_left - 16'd1;
                        end
                    end
                end
                sps_pkg::REQ_MOVE: begin
                    if (r_moving) begin
                        rej = 1'b1;
                    end else if (i_req.step_count != 16'd0) begin
                        step_reverse = i_req.step_count[15];
                        n_reverse    = i_req.step_count[15];
                        n_steps_left = move_mag - 16'd1;
                        n_moving     = 1'b1;
                        take_step    = 1'b1;
                    end
                end
                sps_pkg::REQ_OFF: begin
                    if (r_moving) begin
                        rej = 1'b1;
                    end else begin
                        n_energised = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end

        if (take_step) begin
            n_phase      = stepped_phase;
            n_energised  = 1'b1;
            n_delay_left = delay_load;
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                sps_pkg::CFG_DRIVE_MODE: begin
                    n_drive_mode = i_cfg_data[0];
                    n_phase      = 3'd0;
                end
                sps_pkg::CFG_STEP_DELAY: begin
                    n_step_delay = i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_mode <= sps_pkg::MODE_HALF;
            r_step_delay <= sps_pkg::STEP_DELAY_RESET;
            r_phase      <= 3'd0;
            r_energised  <= 1'b0;
            r_steps_left <= 16'd0;
            r_reverse    <= 1'b0;
            r_delay_left <= 16'd0;
            r_moving     <= 1'b0;
        end else begin
            r_drive_mode <= n_drive_mode;
            r_step_delay <= n_step_delay;
            r_phase      <= n_phase;
            r_energised  <= n_energised;
            r_steps_left <= n_steps_left;
            r_reverse    <= n_reverse;
            r_delay_left <= n_delay_left;
            r_moving     <= n_moving;
        end
    end

    always_comb begin
        o_result.coils    = n_energised ? sps_pkg::coil_lookup(n_drive_mode, n_phase) : 4'd0;
        o_result.busy_res = n_moving;
        o_result.done_res = done;
        o_result.rejected = rej;
    end

endmodule

// ----- rtl/stepper_phase_sequencer_top.sv -----
// Unipolar stepper phase sequencer.
// Input stream: one transfer per request. tuser carries req_type (tick, move,
// coils off), tdata carries the signed step_count. Each input transfer yields
// exactly one output transfer with coil drive bits and status flags.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 drive mode, 1 step delay); write only while no request is in flight.
// Path: input register, then result register after the state update.
// Throughput: one transfer per cycle while i_m_tready is high, set by the
// state update between the two registers.
// Stall: when i_m_tready is low the result register holds, the input register
// fills, and o_s_tready drops only once both are occupied.
// Reset: synchronous, active low; coils off, phase 0, half-step mode,
// step delay 2944, both registers empty.
`include "assert_macros.svh"

module stepper_phase_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] step_count
    input  logic [1:0]  i_s_tuser,   // [1:0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [3:0] coils, [4] busy_res, [5] done_res,
                                     // [6] rejected, [7] zero
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic              r_in_valid;
    sps_pkg::t_req     r_in;
    logic              r_out_valid;
    sps_pkg::t_result  r_out;
    sps_pkg::t_result  core_result;
    logic              advance;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.req_type   <= sps_pkg::t_req_type'(i_s_tuser);
            r_in.step_count <= i_s_tdata;
        end
    end

    sps_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_req       (r_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out.rejected, r_out.done_res, r_out.busy_res, r_out.coils};

    `ASSERT_AT(a_done_not_busy, !(r_out_valid && r_out.done_res && r_out.busy_res),
        "done reported while still busy")
    `ASSERT_AT(a_reject_busy, !(r_out_valid && r_out.rejected && !r_out.busy_res),
        "rejection reported while idle")
    `ASSERT_NEXT(a_in_hold, r_in_valid && !advance,
        r_in_valid && $stable(r_in.step_count) && $stable(r_in.req_type),
        "held request changed before the state update")
    `ASSERT_NEXT(a_busy_coils, r_out_valid && r_out.busy_res && advance,
        !r_out.done_res || !r_out.busy_res,
        "result register holds inconsistent status")

endmodule

// ----- tb/sps_checker.sv -----
`timescale 1ns / 1ps

module sps_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] step_count
    input  logic [1:0]  i_s_tuser,   // [1:0] req_type
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // [3:0] coils, [4] busy_res, [5] done_res,
                                     // [6] rejected, [7] zero
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output logic        o_motor_busy,
    output int          o_result_count,
    output int          o_done_count,
    output int          o_reject_count
);

    localparam logic [3:0] HALF_COILS [8] = '{
        4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9
    };
    localparam logic [3:0] WAVE_COILS [4] = '{4'd1, 4'd2, 4'd4, 4'd8};

    logic        mode_sel    = sps_pkg::MODE_HALF;
    logic [15:0] delay_reg   = sps_pkg::STEP_DELAY_RESET;
    logic [2:0]  phase_idx   = '0;
    logic        coils_on    = 1'b0;
    logic [15:0] steps_rem   = '0;
    logic        reverse_dir = 1'b0;
    logic [15:0] delay_rem   = '0;
    logic        moving      = 1'b0;

    sps_pkg::t_result coil_status_q [$];
    int      fails   = 0;
    int      results = 0;
    int      dones   = 0;
    int      rejects = 0;

    function automatic logic [3:0] drive_bits();
        logic [3:0] bits;
        if (!coils_on) begin
            bits = 4'd0;
        end else if (mode_sel == sps_pkg::MODE_WAVE) begin
            bits = WAVE_COILS[phase_idx[1:0]];
        end else begin
            bits = HALF_COILS[phase_idx];
        end
        return bits;
    endfunction

    task automatic take_step();
        logic [3:0] len;
        logic [3:0] p;
        len = (mode_sel == sps_pkg::MODE_WAVE) ? 4'd4 : 4'd8;
        p   = {1'b0, phase_idx} % len;
        p   = reverse_dir ? (p + len - 4'd1) % len : (p + 4'd1) % len;
        phase_idx = p[2:0];
        coils_on  = 1'b1;
        if (steps_rem != 16'd0) begin
            steps_rem--;
        end
        delay_rem = (delay_reg == 16'd0) ? 16'd1 : delay_reg;
    endtask

    task automatic predict_request(input logic [1:0] req, input logic [15:0] count,
                                   output sps_pkg::t_result next_out);
        logic done;
        logic rej;
        done = 1'b0;
        rej  = 1'b0;
        if (req == sps_pkg::REQ_TICK) begin
            if (moving) begin
                if (delay_rem <= 16'd1) begin
                    delay_rem = 16'd0;
                    if (steps_rem != 16'd0) begin
                        take_step();
                    end else begin
                        moving = 1'b0;
                        done   = 1'b1;
                    end
                end else begin
                    delay_rem--;
                end
            end
        end else if (req == sps_pkg::REQ_MOVE) begin
            if (moving) begin
                rej = 1'b1;
            end else if (count != 16'd0) begin
                reverse_dir = count[15];
                steps_rem   = count[15] ? -count : count;
                moving      = 1'b1;
                take_step();
            end
        end else if (req == sps_pkg::REQ_OFF) begin
            if (moving) begin
                rej = 1'b1;
            end else begin
                coils_on = 1'b0;
            end
        end
        next_out.coils    = drive_bits();
        next_out.busy_res = moving;
        next_out.done_res = done;
        next_out.rejected = rej;
    endtask

    always @(posedge i_clk) begin
        sps_pkg::t_result got;
        sps_pkg::t_result want;
        if (!i_rst_n) begin
            mode_sel    = sps_pkg::MODE_HALF;
            delay_reg   = sps_pkg::STEP_DELAY_RESET;
            phase_idx   = '0;
            coils_on    = 1'b0;
            steps_rem   = '0;
            reverse_dir = 1'b0;
            delay_rem   = '0;
            moving      = 1'b0;
            coil_status_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == sps_pkg::CFG_DRIVE_MODE) begin
                    mode_sel  = i_cfg_data[0];
                    phase_idx = '0;
                end else begin
                    delay_reg = i_cfg_data;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.coils    = i_m_tdata[3:0];
                got.busy_res = i_m_tdata[4];
                got.done_res = i_m_tdata[5];
                got.rejected = i_m_tdata[6];
                results++;
                if (got.done_res) begin
                    dones++;
                end
                if (got.rejected) begin
                    rejects++;
                end
                if (coil_status_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("%0t: unexpected result transfer, data %h", $realtime,
                                 i_m_tdata);
                    end
                end else begin
                    want = coil_status_q.pop_front();
                    if (got != want) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("%0t: result %0d exp %h/%b/%b/%b got %h/%b/%b/%b",
                                     $realtime, results, want.coils, want.busy_res,
                                     want.done_res, want.rejected, got.coils,
                                     got.busy_res, got.done_res, got.rejected);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_request(i_s_tuser, i_s_tdata, want);
                coil_status_q.push_back(want);
            end
        end
        o_fail_count   <= fails;
        o_pending      <= coil_status_q.size();
        o_motor_busy   <= moving;
        o_result_count <= results;
        o_done_count   <= dones;
        o_reject_count <= rejects;
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         RAND_PHASES = 8;
    localparam int         CALM_PHASE  = 3;
    localparam logic [15:0] PHASE_DELAY [RAND_PHASES] = '{
        16'd1, 16'd2, 16'd0, 16'd1, 16'd3, 16'd2, 16'd5, 16'd1
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic [15:0] i_s_tdata   = '0;
    logic [1:0]  i_s_tuser   = '0;
    logic        i_m_tready  = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data  = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [7:0]  o_m_tdata;

    int   fail_count;
    int   pending;
    int   result_count;
    int   done_count;
    int   reject_count;
    logic motor_busy;
    logic calm = 1'b0;
    int   settings_used = 0;

    stepper_phase_sequencer_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    sps_checker u_motion_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_tvalid),
        .i_s_tready     (o_s_tready),
        .i_s_tdata      (i_s_tdata),
        .i_s_tuser      (i_s_tuser),
        .i_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .i_m_tdata      (o_m_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_motor_busy   (motor_busy),
        .o_result_count (result_count),
        .o_done_count   (done_count),
        .o_reject_count (reject_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("TEST FAILED");
        $finish;
    end

    // hold off once for a long stretch when the sender runs without gaps
    initial begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (calm && !held) begin
                held      = 1'b1;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_tready <= calm || ($urandom_range(0, 99) >= 34);
            end
        end
    end

    task automatic send_request(input logic [1:0] req, input logic [15:0] count);
        if (!calm && $urandom_range(0, 99) < 34) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= count;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // drain every transfer in flight, then write both registers
    task automatic load_settings(input logic mode, input logic [15:0] delay);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sps_pkg::CFG_DRIVE_MODE;
        i_cfg_data  <= {15'd0, mode};
        @(posedge i_clk);
        i_cfg_index <= sps_pkg::CFG_STEP_DELAY;
        i_cfg_data  <= delay;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_until_idle();
        do send_request(sps_pkg::REQ_TICK, 16'($urandom)); while (motor_busy);
    endtask

    task automatic random_request();
        int          pick;
        logic [15:0] count;
        pick  = $urandom_range(0, 99);
        count = 16'($urandom);
        if (pick < 60) begin
            send_request(sps_pkg::REQ_TICK, count);
        end else if (pick < 80) begin
            if (!motor_busy) begin
                if ($urandom_range(0, 19) == 0) begin
                    count = 16'd0;
                end else begin
                    count = 16'($urandom_range(1, 6));
                    if ($urandom_range(0, 1) == 1) begin
                        count = -count;
                    end
                end
            end
            send_request(sps_pkg::REQ_MOVE, count);
        end else if (pick < 92) begin
            send_request(sps_pkg::REQ_OFF, count);
        end else begin
            send_request(REQ_UNUSED, count);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(sps_pkg::REQ_TICK, 16'h0000);
        send_request(sps_pkg::REQ_OFF, 16'hFFFF);
        send_request(REQ_UNUSED, 16'h8000);
        send_request(sps_pkg::REQ_MOVE, 16'h0000);

        load_settings(sps_pkg::MODE_HALF, 16'd2);
        send_request(sps_pkg::REQ_MOVE, 16'd1);
        send_request(sps_pkg::REQ_MOVE, 16'h7FFF);
        send_request(sps_pkg::REQ_OFF, 16'h0000);
        send_request(REQ_UNUSED, 16'hFFFF);
        run_until_idle();
        send_request(sps_pkg::REQ_OFF, 16'h5555);

        load_settings(sps_pkg::MODE_HALF, 16'd0);
        send_request(sps_pkg::REQ_MOVE, 16'd3);
        run_until_idle();

        load_settings(sps_pkg::MODE_WAVE, 16'd1);
        send_request(sps_pkg::REQ_MOVE, 16'hFFFB);
        run_until_idle();
        send_request(sps_pkg::REQ_MOVE, 16'd9);
        run_until_idle();

        // switch table in the middle of a move
        load_settings(sps_pkg::MODE_HALF, 16'd2);
        send_request(sps_pkg::REQ_MOVE, 16'd6);
        repeat (3) send_request(sps_pkg::REQ_TICK, 16'hAAAA);
        load_settings(sps_pkg::MODE_WAVE, 16'd2);
        run_until_idle();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            load_settings(ph[0], PHASE_DELAY[ph]);
            calm <= (ph == CALM_PHASE);
            repeat ((ph == CALM_PHASE) ? 80 : 35) random_request();
        end
        calm <= 1'b0;

        // most negative count, then a table switch and long delay mid-move
        load_settings(sps_pkg::MODE_HALF, 16'd1);
        send_request(sps_pkg::REQ_MOVE, 16'h8000);
        repeat (20) send_request(sps_pkg::REQ_TICK, 16'($urandom));
        load_settings(sps_pkg::MODE_WAVE, 16'hFFFF);
        send_request(sps_pkg::REQ_MOVE, 16'd1);
        repeat (4) send_request(sps_pkg::REQ_TICK, 16'($urandom));

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Checked %0d results: %0d moves completed, %0d requests rejected, %0d settings.",
                 result_count, done_count, reject_count, settings_used);
        $display("Both tables, delays 0 to 65535, full-range counts, busy rejects, mid-move mode.");
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/sps_pkg.sv
rtl/sps_core.sv
rtl/stepper_phase_sequencer_top.sv
tb/sps_checker.sv
tb/tb_top.sv
